/* rtl/core/rlcp_pkg.sv */
package rlcp_pkg;

    // Command characters
    localparam logic [7:0] CHAR_W = 8'h57;
    localparam logic [7:0] CHAR_R = 8'h52;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_B = 8'h42;
    localparam logic [7:0] CHAR_0 = 8'h30;
    localparam logic [7:0] CHAR_9 = 8'h39;

    // Saturation limit for one level
    localparam logic [9:0] LEVEL_MAX = 10'd255;

    // Digit counts that close a three-digit group
    localparam logic [3:0] GROUP_RED_END   = 4'd3;
    localparam logic [3:0] GROUP_GREEN_END = 4'd6;
    localparam logic [3:0] GROUP_BLUE_END  = 4'd9;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_W    = 3'd1,
        MODE_R    = 3'd2,
        MODE_G    = 3'd3,
        MODE_B    = 3'd4
    } cmd_mode_t;

    // Parser state carried from request to request
    typedef struct packed {
        cmd_mode_t   mode;
        logic [3:0]  count;
        logic [9:0]  acc;
        logic [7:0]  pend_red;
        logic [7:0]  pend_green;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } parse_state_t;

endpackage

/* rtl/core/rlcp_parse.sv */
module rlcp_parse
    import rlcp_pkg::*;
(
    input  parse_state_t st,
    input  logic [7:0]   rx_byte,
    output parse_state_t st_next,
    output logic         updated
);

    logic [9:0] acc_sum;
    logic [3:0] count_inc;
    logic [7:0] level;
    logic       is_digit;

    // Accumulate one decimal digit: acc * 10 + digit, acc stays below 100
    assign is_digit  = (rx_byte >= CHAR_0) && (rx_byte <= CHAR_9);
    assign acc_sum   = {st.acc[6:0], 3'b000} + {st.acc[8:0], 1'b0}
                       + {6'd0, rx_byte[3:0]};
    assign count_inc = st.count + 4'd1;
    assign level     = (acc_sum > LEVEL_MAX) ? LEVEL_MAX[7:0] : acc_sum[7:0];

    // Next state
    always_comb begin
        st_next = st;
        updated = 1'b0;
        case (st.mode)
            MODE_W, MODE_R, MODE_G, MODE_B: begin
                if (is_digit) begin
                    st_next.acc   = acc_sum;
                    st_next.count = count_inc;
                    if (count_inc == GROUP_RED_END || count_inc == GROUP_GREEN_END ||
                        count_inc == GROUP_BLUE_END) begin
                        st_next.acc = '0;
                        if (st.mode == MODE_W) begin
                            if (count_inc == GROUP_RED_END) begin
                                st_next.pend_red = level;
                            end else if (count_inc == GROUP_GREEN_END) begin
                                st_next.pend_green = level;
                            end else begin
                                st_next.red   = st.pend_red;
                                st_next.green = st.pend_green;
                                st_next.blue  = level;
                                updated       = 1'b1;
                            end
                        end else begin
                            if (st.mode == MODE_R) begin
                                st_next.red = level;
                            end else if (st.mode == MODE_G) begin
                                st_next.green = level;
                            end else begin
                                st_next.blue = level;
                            end
                            updated = 1'b1;
                        end
                        if (updated) begin
                            st_next.mode  = MODE_IDLE;
                            st_next.count = '0;
                        end
                    end
                end
            end
            default: begin
                // idle: only a command letter starts anything
                st_next.count = '0;
                st_next.acc   = '0;
                case (rx_byte)
                    CHAR_W:  st_next.mode = MODE_W;
                    CHAR_R:  st_next.mode = MODE_R;
                    CHAR_G:  st_next.mode = MODE_G;
                    CHAR_B:  st_next.mode = MODE_B;
                    default: st_next.mode = MODE_IDLE;
                endcase
            end
        endcase
    end

endmodule

/* rtl/core/rgb_level_command_parser.sv */
// Channel  Direction  Handshake          Payload
// s_       in         s_valid / s_ready  s_rx_byte[7:0]
// m_       out        m_valid / m_ready  m_red_level, m_green_level, m_blue_level,
//                                        m_levels_updated
//
// Result is registered: an accepted request passes the input register, then the parse
// step feeding the result register. One request per cycle sustained while m_ready is high.
// aresetn (synchronous, active low) returns the parser to idle with all levels zero.
// A stalled result holds; the input register still takes a request while it is empty,
// or while the result register is free or being drained in the same cycle.
module rgb_level_command_parser
    import rlcp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_red_level,
    output logic [7:0] m_green_level,
    output logic [7:0] m_blue_level,
    output logic       m_levels_updated
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic         parse_updated;
    logic         out_valid_reg;
    logic [7:0]   out_red_reg;
    logic [7:0]   out_green_reg;
    logic [7:0]   out_blue_reg;
    logic         out_updated_reg;
    logic         out_free;
    logic         advance;

    // Pipeline flow control
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;

    rlcp_parse u_parse (
        .st      (state_reg),
        .rx_byte (in_byte_reg),
        .st_next (state_next),
        .updated (parse_updated)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{mode: MODE_IDLE, default: '0};
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
        if (advance) begin
            out_red_reg     <= state_next.red;
            out_green_reg   <= state_next.green;
            out_blue_reg    <= state_next.blue;
            out_updated_reg <= parse_updated;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_red_level      = out_red_reg;
    assign m_green_level    = out_green_reg;
    assign m_blue_level     = out_blue_reg;
    assign m_levels_updated = out_updated_reg;

    // Checks
    a_commit_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && parse_updated |=> state_reg.mode == MODE_IDLE && state_reg.count == 4'd0)
        else $error("parser not idle after commit");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.count <= 4'd8)
        else $error("digit count out of range");

    a_acc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.acc < 10'd100)
        else $error("digit accumulator holds a full group");

    a_advance_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("parsed request did not reach result register");

endmodule

/* sim/tb.sv */
module tb
    import rlcp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // One result beat: committed levels plus the update flag
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       updated;
    } level_result_t;

    // Tracks parser state from accepted requests and checks each result beat
    class level_scoreboard;
        cmd_mode_t     cur_mode;
        logic [3:0]    digits_taken;
        logic [9:0]    group_value;
        logic [7:0]    held_red;
        logic [7:0]    held_green;
        logic [7:0]    lvl_red;
        logic [7:0]    lvl_green;
        logic [7:0]    lvl_blue;
        level_result_t expected_levels[$];
        int unsigned   mismatches;
        int unsigned   results_seen;
        int unsigned   updates_seen;

        function new();
            cur_mode     = MODE_IDLE;
            digits_taken = '0;
            group_value  = '0;
            held_red     = '0;
            held_green   = '0;
            lvl_red      = '0;
            lvl_green    = '0;
            lvl_blue     = '0;
            mismatches   = 0;
            results_seen = 0;
            updates_seen = 0;
        endfunction

        // Advance the parser by one accepted byte and queue the expected beat
        function void note_byte(logic [7:0] rx);
            level_result_t exp_beat;
            logic [7:0]    grp_level;
            logic          done;
            int            acc_next;
            done = 1'b0;
            if (cur_mode == MODE_IDLE) begin
                digits_taken = '0;
                group_value  = '0;
                case (rx)
                    CHAR_W:  cur_mode = MODE_W;
                    CHAR_R:  cur_mode = MODE_R;
                    CHAR_G:  cur_mode = MODE_G;
                    CHAR_B:  cur_mode = MODE_B;
                    default: cur_mode = MODE_IDLE;
                endcase
            end else if (rx >= CHAR_0 && rx <= CHAR_9) begin
                acc_next     = int'(group_value) * 10 + int'(rx - CHAR_0);
                group_value  = acc_next[9:0];
                digits_taken = digits_taken + 4'd1;
                if (digits_taken == GROUP_RED_END || digits_taken == GROUP_GREEN_END ||
                    digits_taken == GROUP_BLUE_END) begin
                    grp_level   = (group_value > LEVEL_MAX) ? 8'd255 : group_value[7:0];
                    group_value = '0;
                    if (cur_mode == MODE_W) begin
                        if (digits_taken == GROUP_RED_END) begin
                            held_red = grp_level;
                        end else if (digits_taken == GROUP_GREEN_END) begin
                            held_green = grp_level;
                        end else begin
                            lvl_red   = held_red;
                            lvl_green = held_green;
                            lvl_blue  = grp_level;
                            done      = 1'b1;
                        end
                    end else begin
                        case (cur_mode)
                            MODE_R:  lvl_red   = grp_level;
                            MODE_G:  lvl_green = grp_level;
                            default: lvl_blue  = grp_level;
                        endcase
                        done = 1'b1;
                    end
                    if (done) begin
                        cur_mode     = MODE_IDLE;
                        digits_taken = '0;
                    end
                end
            end
            exp_beat.red     = lvl_red;
            exp_beat.green   = lvl_green;
            exp_beat.blue    = lvl_blue;
            exp_beat.updated = done;
            expected_levels.push_back(exp_beat);
        endfunction

        // Compare one result beat with the oldest expectation
        function void check_result(level_result_t got);
            level_result_t exp_beat;
            results_seen++;
            if (got.updated) updates_seen++;
            if (expected_levels.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t: result with nothing expected: r=%0d g=%0d b=%0d upd=%0b",
                             $realtime, got.red, got.green, got.blue, got.updated);
                mismatches++;
                return;
            end
            exp_beat = expected_levels.pop_front();
            if (got.red !== exp_beat.red || got.green !== exp_beat.green ||
                got.blue !== exp_beat.blue || got.updated !== exp_beat.updated) begin
                if (mismatches < 10)
                    $display({"%0t: mismatch exp r=%0d g=%0d b=%0d upd=%0b, ",
                              "got r=%0d g=%0d b=%0d upd=%0b"},
                             $realtime, exp_beat.red, exp_beat.green, exp_beat.blue,
                             exp_beat.updated, got.red, got.green, got.blue, got.updated);
                mismatches++;
            end
        endfunction
    endclass

    localparam int STALL_LIMIT    = 2000;
    localparam int BYTES_PER_PHASE = 450;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic [7:0] m_red_level;
    logic [7:0] m_green_level;
    logic [7:0] m_blue_level;
    logic       m_levels_updated;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned bytes_sent    = 0;
    int unsigned quiet_cycles  = 0;

    level_scoreboard sb = new();

    rgb_level_command_parser DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_red_level      (m_red_level),
        .m_green_level    (m_green_level),
        .m_blue_level     (m_blue_level),
        .m_levels_updated (m_levels_updated)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Receiver backpressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Request and result monitors
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_byte(s_rx_byte);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result({m_red_level, m_green_level, m_blue_level, m_levels_updated});
    end

    // Watchdog: cycles with no handshake on either channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $realtime, STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Present one request, with random idle cycles first, and wait for accept
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i]);
    endtask

    // Noise inside a command: null, a letter, or any non-digit
    function automatic logic [7:0] pick_noise();
        logic [7:0] b;
        case ($urandom_range(3))
            0: b = 8'h00;
            1: b = ($urandom_range(1)) ? CHAR_W : CHAR_R;
            default: begin
                b = 8'($urandom_range(255));
                if (b >= CHAR_0 && b <= CHAR_9) b = b ^ 8'h80;
            end
        endcase
        return b;
    endfunction

    // Group value biased toward the saturation edges
    function automatic int pick_level();
        case ($urandom_range(7))
            0: return 0;
            1: return 255;
            2: return 256;
            3: return 999;
            4: return 254;
            default: return $urandom_range(999);
        endcase
    endfunction

    task automatic send_digits(input int n_digits, input int value);
        int d[3];
        d[0] = value / 100;
        d[1] = (value / 10) % 10;
        d[2] = value % 10;
        for (int i = 0; i < n_digits; i++) begin
            if ($urandom_range(9) == 0) send_byte(pick_noise());
            send_byte(CHAR_0 + 8'(d[i]));
        end
    endtask

    // Mostly complete commands, some truncated ones and raw noise
    task automatic send_command();
        logic [7:0] letter;
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                send_byte(CHAR_W);
                for (int g = 0; g < 3; g++) send_digits(3, pick_level());
            end
            4, 5, 6: begin
                case ($urandom_range(2))
                    0: letter = CHAR_R;
                    1: letter = CHAR_G;
                    default: letter = CHAR_B;
                endcase
                send_byte(letter);
                send_digits(3, pick_level());
            end
            7: begin
                send_byte(($urandom_range(1)) ? CHAR_W : CHAR_B);
                send_digits($urandom_range(2, 1), pick_level());
            end
            default: begin
                repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
            end
        endcase
    endtask

    task automatic run_phase(input int unsigned idle_pct, input int unsigned stall);
        int unsigned start_count;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        start_count   = bytes_sent;
        while (bytes_sent - start_count < BYTES_PER_PHASE) send_command();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: idle drops, nine-digit command with a null, a letter and
        // non-digits inside, saturation of 999 and 256, single-color commands
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(CHAR_W);
        send_byte(8'h39);
        send_byte(8'h00);
        send_byte(CHAR_R);
        send_text("99000");
        send_byte(8'h2F);
        send_byte(8'h3A);
        send_text("256");
        send_text("G255");
        send_text("B007");
        send_text("R128");

        // Random traffic under each handshake pressure mix
        run_phase(0, 0);
        run_phase(46, 0);
        run_phase(0, 46);
        run_phase(9, 9);
        s_valid <= 1'b0;

        while (sb.expected_levels.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Sent %0d bytes across four pressure mixes; %0d results checked,",
                 bytes_sent, sb.results_seen);
        $display("%0d level updates. Mismatches: %0d, expectations left: %0d",
                 sb.updates_seen, sb.mismatches, sb.expected_levels.size());
        if (sb.mismatches == 0 && sb.expected_levels.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* rgb_level_command_parser.f */
rtl/core/rlcp_pkg.sv
rtl/core/rlcp_parse.sv
rtl/core/rgb_level_command_parser.sv
sim/tb.sv
